/* src/ppnc_pkg.sv */
// ----------------------------------------------------------------------------
// ppnc_pkg
// Shared types, character codes and helper functions for the path name checker.
// ----------------------------------------------------------------------------
package ppnc_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic       CFG_ACCEPT_PATH = 1'b0;
	localparam logic       CFG_LAST_ONLY   = 1'b1;

	localparam logic [1:0] DOT_NONE  = 2'd0;
	localparam logic [1:0] DOT_OTHER = 2'd3;

	typedef struct packed {
		logic       accept_path;
		logic       last_only;
	} cfg_t;

	typedef struct packed {
		logic [7:0] prev_char;
		logic       at_name_start;
		logic       at_seg_start;
		logic [1:0] dot_cnt;
		logic       seg_unport;
		logic       name_bad;
	} name_state_t;

	localparam name_state_t STATE_RST = '{
		prev_char:     8'h00,
		at_name_start: 1'b1,
		at_seg_start:  1'b1,
		dot_cnt:       DOT_NONE,
		seg_unport:    1'b0,
		name_bad:      1'b0
	};

	function automatic logic char_allowed(input logic [7:0] c);
		logic upper, lower, digit;
		upper = (c >= 8'h41) && (c <= 8'h5A);
		lower = (c >= 8'h61) && (c <= 8'h7A);
		digit = (c >= 8'h30) && (c <= 8'h39);
		return upper || lower || digit || (c == CH_UNDER) || (c == CH_DASH) ||
			(c == CH_DOT) || (c == CH_SPACE);
	endfunction

	function automatic logic is_dot_name(input logic [1:0] cnt);
		return (cnt == 2'd1) || (cnt == 2'd2);
	endfunction

endpackage

/* src/ppnc_cfg.sv */
// ----------------------------------------------------------------------------
// ppnc_cfg
// Configuration registers, written through a valid/ready request channel.
// ----------------------------------------------------------------------------
module ppnc_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic            cfg_data,
	output ppnc_pkg::cfg_t  cfg
);

	ppnc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accept_path <= 1'b1;
			cfg_q.last_only   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ppnc_pkg::CFG_ACCEPT_PATH: cfg_q.accept_path <= cfg_data;
				ppnc_pkg::CFG_LAST_ONLY:   cfg_q.last_only   <= cfg_data;
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

endmodule

/* src/ppnc_step.sv */
// ----------------------------------------------------------------------------
// ppnc_step
// Per-character rule checks: next name state and verdict for one request.
// ----------------------------------------------------------------------------
module ppnc_step (
	input  ppnc_pkg::cfg_t         cfg,
	input  ppnc_pkg::name_state_t  st,
	input  logic [7:0]             character,
	input  logic                   last,
	input  logic                   empty_name,
	output ppnc_pkg::name_state_t  st_nxt,
	output logic                   emit,
	output logic                   ok
);

	always_comb begin
		logic       bad;
		logic       unp;
		logic [1:0] dots;
		logic       is_slash;

		is_slash = (character == ppnc_pkg::CH_SLASH);
		bad      = st.name_bad;
		unp      = st.seg_unport;
		dots     = st.dot_cnt;
		st_nxt   = st;
		emit     = 1'b0;
		ok       = 1'b0;

		if (empty_name) begin
			st_nxt = ppnc_pkg::STATE_RST;
			emit   = 1'b1;
		end else if (is_slash) begin
			if (st.at_name_start || !cfg.accept_path || st.at_seg_start || last) begin
				bad = 1'b1;
			end
			if (!st.at_seg_start) begin
				if (ppnc_pkg::is_dot_name(st.dot_cnt)) begin
					bad = 1'b1;
				end
				if (st.prev_char == ppnc_pkg::CH_SPACE || st.prev_char == ppnc_pkg::CH_DOT) begin
					unp = 1'b1;
				end
				if (!cfg.last_only && unp) begin
					bad = 1'b1;
				end
			end
			st_nxt.prev_char     = character;
			st_nxt.at_name_start = 1'b0;
			st_nxt.at_seg_start  = 1'b1;
			st_nxt.dot_cnt       = ppnc_pkg::DOT_NONE;
			st_nxt.seg_unport    = 1'b0;
			st_nxt.name_bad      = bad;
		end else begin
			if (!ppnc_pkg::char_allowed(character)) begin
				unp = 1'b1;
			end
			if (st.at_seg_start &&
				(character == ppnc_pkg::CH_SPACE || character == ppnc_pkg::CH_DASH)) begin
				unp = 1'b1;
			end
			if (!st.at_seg_start && character == ppnc_pkg::CH_SPACE &&
				st.prev_char == ppnc_pkg::CH_SPACE) begin
				unp = 1'b1;
			end
			if (character == ppnc_pkg::CH_DOT) begin
				if (dots != ppnc_pkg::DOT_OTHER) begin
					dots = dots + 2'd1;
				end
			end else begin
				dots = ppnc_pkg::DOT_OTHER;
			end
			if (last) begin
				// close the final segment, always with portability checks
				if (ppnc_pkg::is_dot_name(dots)) begin
					bad = 1'b1;
				end
				if (character == ppnc_pkg::CH_SPACE || character == ppnc_pkg::CH_DOT) begin
					unp = 1'b1;
				end
				if (unp) begin
					bad = 1'b1;
				end
			end
			st_nxt.prev_char     = character;
			st_nxt.at_name_start = 1'b0;
			st_nxt.at_seg_start  = 1'b0;
			st_nxt.dot_cnt       = dots;
			st_nxt.seg_unport    = unp;
			st_nxt.name_bad      = bad;
		end

		if (!empty_name && last) begin
			emit   = 1'b1;
			ok     = !bad;
			st_nxt = ppnc_pkg::STATE_RST;
		end
	end

endmodule

/* src/portable_path_name_checker.sv */
// ----------------------------------------------------------------------------
// portable_path_name_checker
// Path: the verdict is formed from the input register and held in the result register.
// Throughput: one character per cycle; the input register frees whenever the
// result register is empty or being taken, so stalls only come from out_ready.
// Reset: clears the name state, both registers and sets accept_path=1, last_only=0.
// ----------------------------------------------------------------------------
module portable_path_name_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       last,
	input  logic       empty_name,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       name_ok,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic       cfg_data
);

	ppnc_pkg::cfg_t        cfg;
	ppnc_pkg::name_state_t state_q;
	ppnc_pkg::name_state_t state_nxt;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       empty_s1;

	logic       emit;
	logic       ok;
	logic       out_free;
	logic       adv_s1;

	logic       out_valid_q;
	logic       name_ok_q;

	ppnc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppnc_step u_step (
		.cfg        (cfg),
		.st         (state_q),
		.character  (char_s1),
		.last       (last_s1),
		.empty_name (empty_s1),
		.st_nxt     (state_nxt),
		.emit       (emit),
		.ok         (ok)
	);

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= character;
			last_s1  <= last;
			empty_s1 <= empty_name;
		end
	end

	// name state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppnc_pkg::STATE_RST;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			name_ok_q <= ok;
		end
	end

	assign out_valid = out_valid_q;
	assign name_ok   = name_ok_q;

endmodule

/* bench/portable_path_name_checker_test.sv */
// ----------------------------------------------------------------------------
// portable_path_name_checker_test
// Drives path names into the checker one byte per request and compares every
// verdict with the table's expectation or a cycle-free predictor of the naming rules.
// A short table of hand-picked names comes first, then phases of random names under
// each mode setting, with random idling on both sides and up to two long receiver holds.
// ----------------------------------------------------------------------------
module portable_path_name_checker_test;

	localparam int ITEM_TARGET    = 1500;
	localparam int QUIET_ITEMS    = 200;
	localparam int LONG_HOLD      = 120;
	localparam int SETTLE_CYCLES  = 6;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum logic [1:0] {NAME_REJECTED, NAME_ACCEPTED, FROM_PREDICTOR} want_t;
	typedef enum logic [1:0] {SHAPE_CLEAN, SHAPE_DOTS, SHAPE_NOISE} shape_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
		logic       emp;
		want_t      want;
	} probe_t;

	localparam probe_t DIRECTED [28] = '{
		'{8'hFF, 1'b1, 1'b1, NAME_REJECTED},
		'{"a",   1'b1, 1'b0, NAME_ACCEPTED},
		'{8'h00, 1'b1, 1'b0, NAME_REJECTED},
		'{8'hFF, 1'b1, 1'b0, NAME_REJECTED},
		'{"/",   1'b1, 1'b0, NAME_REJECTED},
		'{".",   1'b1, 1'b0, NAME_REJECTED},
		'{".",   1'b0, 1'b0, FROM_PREDICTOR},
		'{".",   1'b1, 1'b0, NAME_REJECTED},
		'{"a",   1'b0, 1'b0, FROM_PREDICTOR},
		'{"/",   1'b0, 1'b0, FROM_PREDICTOR},
		'{"b",   1'b1, 1'b0, NAME_ACCEPTED},
		'{"a",   1'b0, 1'b0, FROM_PREDICTOR},
		'{"/",   1'b0, 1'b0, FROM_PREDICTOR},
		'{"/",   1'b0, 1'b0, FROM_PREDICTOR},
		'{"b",   1'b1, 1'b0, NAME_REJECTED},
		'{"-",   1'b0, 1'b0, FROM_PREDICTOR},
		'{"a",   1'b1, 1'b0, NAME_REJECTED},
		'{"a",   1'b0, 1'b0, FROM_PREDICTOR},
		'{"/",   1'b1, 1'b0, NAME_REJECTED},
		'{"a",   1'b0, 1'b0, FROM_PREDICTOR},
		'{" ",   1'b0, 1'b0, FROM_PREDICTOR},
		'{" ",   1'b0, 1'b0, FROM_PREDICTOR},
		'{"b",   1'b1, 1'b0, NAME_REJECTED},
		'{"a",   1'b0, 1'b0, FROM_PREDICTOR},
		'{".",   1'b1, 1'b0, NAME_REJECTED},
		'{"x",   1'b0, 1'b0, FROM_PREDICTOR},
		'{"y",   1'b0, 1'b0, FROM_PREDICTOR},
		'{8'h00, 1'b0, 1'b1, NAME_REJECTED}
	};

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] character   = 8'h00;
	logic       last        = 1'b0;
	logic       empty_name  = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic       name_ok;
	logic       cfg_valid   = 1'b0;
	logic       cfg_ready;
	logic       cfg_index   = 1'b0;
	logic       cfg_data    = 1'b0;

	// predictor copy of the mode registers and the running name state
	logic       allow_path = 1'b1;
	logic       final_only = 1'b0;
	logic [7:0] prev_byte;
	logic       name_fresh;
	logic       seg_fresh;
	logic [1:0] dot_run;
	logic       seg_nonportable;
	logic       name_broken;

	logic       verdict_q [$];
	logic [7:0] name_buf [$];

	int  items_sent  = 0;
	int  mismatches  = 0;
	int  idle_cycles = 0;
	int  tx_gap_pct  = 0;
	int  rx_stall_pct = 0;
	bit  quiet       = 1'b0;
	bit  hold_rx     = 1'b0;

	portable_path_name_checker uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.character  (character),
		.last       (last),
		.empty_name (empty_name),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.name_ok    (name_ok),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_name();
		prev_byte       = 8'h00;
		name_fresh      = 1'b1;
		seg_fresh       = 1'b1;
		dot_run         = ppnc_pkg::DOT_NONE;
		seg_nonportable = 1'b0;
		name_broken     = 1'b0;
	endfunction

	function automatic logic byte_portable(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return 1'b1;
		if (c >= "a" && c <= "z") return 1'b1;
		if (c >= "0" && c <= "9") return 1'b1;
		return c == ppnc_pkg::CH_UNDER || c == ppnc_pkg::CH_DASH ||
			c == ppnc_pkg::CH_DOT || c == ppnc_pkg::CH_SPACE;
	endfunction

	function automatic void add_byte(input logic [7:0] c);
		if (!byte_portable(c)) seg_nonportable = 1'b1;
		if (seg_fresh && (c == ppnc_pkg::CH_SPACE || c == ppnc_pkg::CH_DASH))
			seg_nonportable = 1'b1;
		if (!seg_fresh && c == ppnc_pkg::CH_SPACE && prev_byte == ppnc_pkg::CH_SPACE)
			seg_nonportable = 1'b1;
		if (c == ppnc_pkg::CH_DOT) begin
			if (dot_run != ppnc_pkg::DOT_OTHER) dot_run = dot_run + 2'd1;
		end else begin
			dot_run = ppnc_pkg::DOT_OTHER;
		end
		seg_fresh = 1'b0;
	endfunction

	function automatic void end_segment(input logic [7:0] c, input logic portable);
		if (dot_run == 2'd1 || dot_run == 2'd2) name_broken = 1'b1;
		if (c == ppnc_pkg::CH_SPACE || c == ppnc_pkg::CH_DOT) seg_nonportable = 1'b1;
		if (portable && seg_nonportable) name_broken = 1'b1;
	endfunction

	function automatic void predict_verdict(input logic [7:0] c, input logic lst,
			input logic emp, output logic done, output logic ok);
		done = 1'b0;
		ok   = 1'b0;
		if (emp) begin
			clear_name();
			done = 1'b1;
		end else begin
			if (c == ppnc_pkg::CH_SLASH) begin
				if (name_fresh || !allow_path || seg_fresh || lst) name_broken = 1'b1;
				if (!seg_fresh) end_segment(prev_byte, !final_only);
				seg_fresh       = 1'b1;
				dot_run         = ppnc_pkg::DOT_NONE;
				seg_nonportable = 1'b0;
			end else begin
				add_byte(c);
				if (lst) end_segment(c, 1'b1);
			end
			prev_byte  = c;
			name_fresh = 1'b0;
			if (lst) begin
				done = 1'b1;
				ok   = !name_broken;
				clear_name();
			end
		end
	endfunction

	task automatic push_char(input logic [7:0] c, input logic lst, input logic emp,
			input want_t want);
		logic done;
		logic ok;
		if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		character  <= c;
		last       <= lst;
		empty_name <= emp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_verdict(c, lst, emp, done, ok);
		if (done) verdict_q.push_back(want == FROM_PREDICTOR ? ok : want == NAME_ACCEPTED);
		items_sent++;
	endtask

	task automatic drain_verdicts();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic ap, input logic lo);
		cfg_valid <= 1'b1;
		cfg_index <= ppnc_pkg::CFG_ACCEPT_PATH;
		cfg_data  <= ap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		allow_path = ap;
		cfg_index <= ppnc_pkg::CFG_LAST_ONLY;
		cfg_data  <= lo;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		final_only = lo;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] segment_byte(input int pos, input int len,
			input logic [7:0] prev);
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2:    c = 8'("a" + $urandom_range(0, 25));
			3, 4, 5:    c = 8'("A" + $urandom_range(0, 25));
			6:          c = 8'("0" + $urandom_range(0, 9));
			7:          c = ppnc_pkg::CH_UNDER;
			8:          c = ppnc_pkg::CH_DASH;
			default:    c = $urandom_range(0, 1) ? ppnc_pkg::CH_DOT : ppnc_pkg::CH_SPACE;
		endcase
		if (pos == 0 && (c == ppnc_pkg::CH_SPACE || c == ppnc_pkg::CH_DASH)) c = "k";
		if (pos == len - 1 && (c == ppnc_pkg::CH_SPACE || c == ppnc_pkg::CH_DOT)) c = "z";
		if (c == ppnc_pkg::CH_SPACE && prev == ppnc_pkg::CH_SPACE) c = ppnc_pkg::CH_UNDER;
		return c;
	endfunction

	function automatic logic [7:0] tricky_byte();
		case ($urandom_range(0, 5))
			0:       return ppnc_pkg::CH_SLASH;
			1:       return ppnc_pkg::CH_SPACE;
			2:       return ppnc_pkg::CH_DASH;
			3:       return ppnc_pkg::CH_DOT;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void build_name(input shape_t shape);
		int nseg;
		int len;
		int pos;
		logic [7:0] prev;
		name_buf.delete();
		case (shape)
			SHAPE_NOISE: begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) name_buf.push_back(tricky_byte());
			end
			default: begin
				nseg = (allow_path || $urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 1;
				for (int s = 0; s < nseg; s++) begin
					if (s != 0) name_buf.push_back(ppnc_pkg::CH_SLASH);
					if (shape == SHAPE_DOTS && $urandom_range(0, 1)) begin
						len = $urandom_range(1, 3);
						for (int i = 0; i < len; i++) name_buf.push_back(ppnc_pkg::CH_DOT);
					end else begin
						len  = $urandom_range(1, 8);
						prev = 8'h00;
						for (int i = 0; i < len; i++) begin
							prev = segment_byte(i, len, prev);
							name_buf.push_back(prev);
						end
					end
				end
				if ($urandom_range(0, 99) < 30) begin
					case ($urandom_range(0, 3))
						0:       name_buf.push_front(ppnc_pkg::CH_SLASH);
						1:       name_buf.push_back(ppnc_pkg::CH_SLASH);
						default: begin
							pos = $urandom_range(0, name_buf.size() - 1);
							name_buf[pos] = tricky_byte();
						end
					endcase
				end
			end
		endcase
	endfunction

	task automatic send_name();
		for (int i = 0; i < name_buf.size(); i++)
			push_char(name_buf[i], i == name_buf.size() - 1, 1'b0, FROM_PREDICTOR);
	endtask

	// out_ready: random bursts, one long hold on request, always ready at the end
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				hold_rx = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (quiet || $urandom_range(0, 99) >= rx_stall_pct) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_verdict
		logic want;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("verdict with none pending: name_ok=%0b", name_ok);
			end else begin
				want = verdict_q.pop_front();
				if (name_ok !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("name_ok mismatch: expected %0b got %0b", want, name_ok);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[portable_path_name_checker] ERROR");
			$finish;
		end
	end

	initial begin
		int phase;
		int names;
		int pick;
		int part;
		clear_name();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			push_char(DIRECTED[i].ch, DIRECTED[i].lst, DIRECTED[i].emp, DIRECTED[i].want);
		drain_verdicts();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase < 4)
				set_mode(phase[1], phase[0]);
			else
				set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			case ($urandom_range(0, 2))
				0:       tx_gap_pct = 0;
				1:       tx_gap_pct = 15;
				default: tx_gap_pct = 50;
			endcase
			case ($urandom_range(0, 2))
				0:       rx_stall_pct = 0;
				1:       rx_stall_pct = 25;
				default: rx_stall_pct = 60;
			endcase
			if ((phase == 2 || phase == 6) && !quiet) begin
				tx_gap_pct = 0;
				hold_rx    = 1'b1;
			end
			names = $urandom_range(10, 40);
			for (int n = 0; n < names && items_sent < ITEM_TARGET; n++) begin
				if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
						FROM_PREDICTOR);
				end else if (pick < 10) begin
					build_name(SHAPE_CLEAN);
					part = $urandom_range(1, name_buf.size());
					for (int i = 0; i < part; i++)
						push_char(name_buf[i], 1'b0, 1'b0, FROM_PREDICTOR);
					push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
						FROM_PREDICTOR);
				end else if (pick < 20) begin
					build_name(SHAPE_NOISE);
					send_name();
				end else if (pick < 28) begin
					build_name(SHAPE_DOTS);
					send_name();
				end else begin
					build_name(SHAPE_CLEAN);
					send_name();
				end
			end
			// leave a name open across the mode change now and then
			if (!quiet && $urandom_range(0, 1)) begin
				build_name(SHAPE_CLEAN);
				part = $urandom_range(1, name_buf.size());
				for (int i = 0; i < part; i++)
					push_char(name_buf[i], 1'b0, 1'b0, FROM_PREDICTOR);
			end
			drain_verdicts();
			phase++;
		end

		quiet = 1'b1;
		build_name(SHAPE_CLEAN);
		send_name();
		drain_verdicts();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("[portable_path_name_checker] OK");
		else
			$display("[portable_path_name_checker] ERROR");
		$finish;
	end

endmodule

/* files.f */
src/ppnc_pkg.sv
src/ppnc_cfg.sv
src/ppnc_step.sv
src/portable_path_name_checker.sv
bench/portable_path_name_checker_test.sv
